### src/bda_pkg.sv
// Package with the shared constants and types of the base digit analyser.
`timescale 1ns / 1ps

package bda_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FIELD_W        = 32;
  localparam int COUNT_W        = 6;
  localparam int LOG_W          = 5;
  localparam int MIN_RADIX      = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_ACC,
    ST_FIN
  } bda_state_t;

endpackage

### src/base_digit_analyzer.sv
// Top level of the base digit analyser: request handshakes, sequencer and result register.
`timescale 1ns / 1ps

// Splits a value into its digits in the given base, least significant digit first, and
// returns the digit count, digit sum, digit-reversed value (wrapping at DATA_WIDTH bits),
// a palindrome flag and the floor logarithm. Each digit is found by the shared unit that
// retires one quotient bit and one multiplier bit a cycle; a zero value or a base below
// two does not start the unit. One request is processed at a time; a new one is taken
// while the last result waits.

module base_digit_analyzer #(
  parameter int DATA_WIDTH = bda_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bda_pkg::FIELD_W-1:0]  in_value,
  input  logic [bda_pkg::FIELD_W-1:0]  in_radix,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bda_pkg::COUNT_W-1:0]  out_digit_count,
  output logic [bda_pkg::FIELD_W-1:0]  out_digit_sum,
  output logic [bda_pkg::FIELD_W-1:0]  out_reversed_value,
  output logic                         out_is_palindrome,
  output logic [bda_pkg::LOG_W-1:0]    out_log_floor
);

  localparam int CNTW = $clog2(DATA_WIDTH + 1);
  localparam int XW   = (CNTW > bda_pkg::COUNT_W) ? CNTW : bda_pkg::COUNT_W;

  bda_pkg::bda_state_t   state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] value_r, value_nxt;
  logic [DATA_WIDTH-1:0] radix_r, radix_nxt;
  logic [DATA_WIDTH-1:0] rest_r, rest_nxt;
  logic [DATA_WIDTH-1:0] rev_r, rev_nxt;
  logic [DATA_WIDTH-1:0] sum_r, sum_nxt;
  logic [CNTW-1:0]       cnt_r, cnt_nxt;

  logic [bda_pkg::COUNT_W-1:0] count_out_r;
  logic [bda_pkg::FIELD_W-1:0] sum_out_r;
  logic [bda_pkg::FIELD_W-1:0] rev_out_r;
  logic                        pal_out_r;
  logic [bda_pkg::LOG_W-1:0]   log_out_r;

  logic                  out_load;
  logic                  unit_start;
  logic                  unit_done;
  logic [DATA_WIDTH-1:0] unit_quo;
  logic [DATA_WIDTH-1:0] unit_rem;
  logic [DATA_WIDTH-1:0] unit_prod;
  logic                  base_ok;
  logic [XW-1:0]         cnt_x;
  logic [XW-1:0]         lg_x;

  bda_digit_unit #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_unit (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (unit_start),
    .dividend  (rest_r),
    .divisor   (radix_r),
    .mcand     (rev_r),
    .done      (unit_done),
    .quotient  (unit_quo),
    .remainder (unit_rem),
    .product   (unit_prod)
  );

  assign base_ok = !(radix_r < DATA_WIDTH'(bda_pkg::MIN_RADIX));
  assign cnt_x   = XW'(cnt_r);
  assign lg_x    = cnt_x - XW'(1);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    value_nxt     = value_r;
    radix_nxt     = radix_r;
    rest_nxt      = rest_r;
    rev_nxt       = rev_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    in_ready      = 1'b0;
    unit_start    = 1'b0;
    out_load      = 1'b0;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      bda_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          value_nxt = DATA_WIDTH'(in_value);
          radix_nxt = DATA_WIDTH'(in_radix);
          rest_nxt  = DATA_WIDTH'(in_value);
          rev_nxt   = '0;
          sum_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = bda_pkg::ST_CHECK;
        end
      end
      bda_pkg::ST_CHECK: begin
        if (!base_ok) begin
          state_nxt = bda_pkg::ST_FIN;
        end else if (rest_r == '0) begin
          if (cnt_r == '0) begin
            cnt_nxt = CNTW'(1);
          end
          state_nxt = bda_pkg::ST_FIN;
        end else begin
          unit_start = 1'b1;
          state_nxt  = bda_pkg::ST_RUN;
        end
      end
      bda_pkg::ST_RUN: begin
        if (unit_done) begin
          state_nxt = bda_pkg::ST_ACC;
        end
      end
      bda_pkg::ST_ACC: begin
        rev_nxt   = unit_prod + unit_rem;
        sum_nxt   = sum_r + unit_rem;
        cnt_nxt   = cnt_r + CNTW'(1);
        rest_nxt  = unit_quo;
        state_nxt = bda_pkg::ST_CHECK;
      end
      bda_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = bda_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bda_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bda_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    radix_r <= radix_nxt;
    rest_r  <= rest_nxt;
    rev_r   <= rev_nxt;
    sum_r   <= sum_nxt;
    cnt_r   <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      count_out_r <= cnt_x[bda_pkg::COUNT_W-1:0];
      sum_out_r   <= bda_pkg::FIELD_W'(sum_r);
      rev_out_r   <= bda_pkg::FIELD_W'(rev_r);
      pal_out_r   <= base_ok && (rev_r == value_r);
      log_out_r   <= base_ok ? lg_x[bda_pkg::LOG_W-1:0] : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_digit_count    = count_out_r;
  assign out_digit_sum      = sum_out_r;
  assign out_reversed_value = rev_out_r;
  assign out_is_palindrome  = pal_out_r;
  assign out_log_floor      = log_out_r;

`ifndef ASSERT_OFF
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    unit_done |-> state_r == bda_pkg::ST_RUN)
    else $error("digit unit finished outside the run state");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != bda_pkg::ST_IDLE |-> cnt_r <= CNTW'(DATA_WIDTH))
    else $error("digit count exceeds the data width");

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == bda_pkg::ST_CHECK)
    else $error("accepted request did not start processing");
`endif

endmodule

### src/bda_digit_unit.sv
// Iterative digit unit: restoring division and shift-add multiplication, one bit a cycle.
`timescale 1ns / 1ps

module bda_digit_unit #(
  parameter int DATA_WIDTH = bda_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  input  logic [DATA_WIDTH-1:0] mcand,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] quotient,
  output logic [DATA_WIDTH-1:0] remainder,
  output logic [DATA_WIDTH-1:0] product
);

  localparam int CW = $clog2(DATA_WIDTH);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CW-1:0]         step_r, step_nxt;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] div_r, div_nxt;
  logic [DATA_WIDTH-1:0] prod_r, prod_nxt;
  logic [DATA_WIDTH-1:0] mcand_r, mcand_nxt;
  logic [DATA_WIDTH-1:0] mbits_r, mbits_nxt;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  fits;

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    step_nxt  = step_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    prod_nxt  = prod_r;
    mcand_nxt = mcand_r;
    mbits_nxt = mbits_r;
    shifted   = {rem_r, quo_r[DATA_WIDTH-1]};
    diff      = shifted - {1'b0, div_r};
    fits      = !diff[DATA_WIDTH];
    if (start) begin
      busy_nxt  = 1'b1;
      step_nxt  = CW'(DATA_WIDTH - 1);
      quo_nxt   = dividend;
      rem_nxt   = '0;
      div_nxt   = divisor;
      prod_nxt  = '0;
      mcand_nxt = mcand;
      mbits_nxt = divisor;
    end else if (busy_r) begin
      rem_nxt   = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      quo_nxt   = {quo_r[DATA_WIDTH-2:0], fits};
      prod_nxt  = {prod_r[DATA_WIDTH-2:0], 1'b0}
                  + (mbits_r[DATA_WIDTH-1] ? mcand_r : '0);
      mbits_nxt = {mbits_r[DATA_WIDTH-2:0], 1'b0};
      step_nxt  = step_r - CW'(1);
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r  <= step_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
    prod_r  <= prod_nxt;
    mcand_r <= mcand_nxt;
    mbits_r <= mbits_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign product   = prod_r;

endmodule

### tb/base_digit_analyzer_checker.sv
// Checker for the base digit analyser: predicts each request's digit report and compares it.
`timescale 1ns / 1ps

module base_digit_analyzer_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [bda_pkg::FIELD_W-1:0]  in_value,
  input  logic [bda_pkg::FIELD_W-1:0]  in_radix,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [bda_pkg::COUNT_W-1:0]  out_digit_count,
  input  logic [bda_pkg::FIELD_W-1:0]  out_digit_sum,
  input  logic [bda_pkg::FIELD_W-1:0]  out_reversed_value,
  input  logic                         out_is_palindrome,
  input  logic [bda_pkg::LOG_W-1:0]    out_log_floor,
  output int                           mismatch_count,
  output int                           pending_count
);

  typedef struct {
    logic [bda_pkg::FIELD_W-1:0] value;
    logic [bda_pkg::FIELD_W-1:0] radix;
    logic [bda_pkg::COUNT_W-1:0] digit_count;
    logic [bda_pkg::FIELD_W-1:0] digit_sum;
    logic [bda_pkg::FIELD_W-1:0] reversed_value;
    logic                        is_palindrome;
    logic [bda_pkg::LOG_W-1:0]   log_floor;
  } digit_report_t;

  digit_report_t expected_reports[$];
  int            reported;

  function automatic digit_report_t decompose(input logic [bda_pkg::FIELD_W-1:0] value,
                                              input logic [bda_pkg::FIELD_W-1:0] radix);
    digit_report_t               rep;
    logic [bda_pkg::FIELD_W-1:0] rest;
    logic [bda_pkg::FIELD_W-1:0] digit;
    logic [bda_pkg::FIELD_W-1:0] sum;
    logic [bda_pkg::FIELD_W-1:0] rev;
    int                          ndigits;
    int                          log_value;
    rep.value          = value;
    rep.radix          = radix;
    rep.digit_count    = '0;
    rep.digit_sum      = '0;
    rep.reversed_value = '0;
    rep.is_palindrome  = 1'b0;
    rep.log_floor      = '0;
    if (radix < bda_pkg::MIN_RADIX) return rep;
    rest    = value;
    sum     = '0;
    rev     = '0;
    ndigits = 0;
    while (rest != 0) begin
      digit   = rest % radix;
      ndigits = ndigits + 1;
      sum     = sum + digit;
      // The product is truncated to the field width, so the reversal wraps.
      rev     = rev * radix + digit;
      rest    = rest / radix;
    end
    if (value == 0) ndigits = 1;
    log_value          = ndigits - 1;
    rep.digit_count    = ndigits[bda_pkg::COUNT_W-1:0];
    rep.digit_sum      = sum;
    rep.reversed_value = rev;
    rep.is_palindrome  = (rev == value);
    rep.log_floor      = log_value[bda_pkg::LOG_W-1:0];
    return rep;
  endfunction

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    reported       = 0;
  end

  always @(posedge clk) begin : watch
    digit_report_t want;
    if (rst_n) begin
      if (in_valid && in_ready) expected_reports.push_back(decompose(in_value, in_radix));
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          mismatch_count++;
          if (reported < 10)
            $display("%0t: result with no request outstanding: count=%0d sum=%h",
                     $realtime, out_digit_count, out_digit_sum,
                     " rev=%h pal=%0d log=%0d",
                     out_reversed_value, out_is_palindrome, out_log_floor);
          reported++;
        end else begin
          want = expected_reports.pop_front();
          if (out_digit_count !== want.digit_count || out_digit_sum !== want.digit_sum ||
              out_reversed_value !== want.reversed_value ||
              out_is_palindrome !== want.is_palindrome || out_log_floor !== want.log_floor) begin
            mismatch_count++;
            if (reported < 10) begin
              $display("%0t: value=%h radix=%h", $realtime, want.value, want.radix);
              $display("  expected count=%0d sum=%h rev=%h pal=%0d log=%0d",
                       want.digit_count, want.digit_sum, want.reversed_value,
                       want.is_palindrome, want.log_floor);
              $display("  actual   count=%0d sum=%h rev=%h pal=%0d log=%0d",
                       out_digit_count, out_digit_sum, out_reversed_value,
                       out_is_palindrome, out_log_floor);
            end
            reported++;
          end
        end
      end
      pending_count = expected_reports.size();
    end
  end

endmodule

### tb/base_digit_analyzer_tb.sv
// Testbench top of the base digit analyser: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module base_digit_analyzer_tb;

  localparam int RANDOM_REQUESTS = 517;
  localparam int LONG_HOLD       = 3000;
  localparam int DRAIN_CYCLES    = 1200;

  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC} sink_mode_t;

  logic                        clk      = 1'b0;
  logic                        rst_n    = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [bda_pkg::FIELD_W-1:0] in_value = '0;
  logic [bda_pkg::FIELD_W-1:0] in_radix = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [bda_pkg::COUNT_W-1:0] out_digit_count;
  logic [bda_pkg::FIELD_W-1:0] out_digit_sum;
  logic [bda_pkg::FIELD_W-1:0] out_reversed_value;
  logic                        out_is_palindrome;
  logic [bda_pkg::LOG_W-1:0]   out_log_floor;

  int mismatch_count;
  int pending_count;
  int burst_left = 0;
  bit long_hold_wanted = 1'b0;

  base_digit_analyzer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_value          (in_value),
    .in_radix          (in_radix),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digit_count   (out_digit_count),
    .out_digit_sum     (out_digit_sum),
    .out_reversed_value(out_reversed_value),
    .out_is_palindrome (out_is_palindrome),
    .out_log_floor     (out_log_floor)
  );

  base_digit_analyzer_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_value          (in_value),
    .in_radix          (in_radix),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digit_count   (out_digit_count),
    .out_digit_sum     (out_digit_sum),
    .out_reversed_value(out_reversed_value),
    .out_is_palindrome (out_is_palindrome),
    .out_log_floor     (out_log_floor),
    .mismatch_count    (mismatch_count),
    .pending_count     (pending_count)
  );

  always #10 clk = ~clk;

  task automatic offer_request(input logic [bda_pkg::FIELD_W-1:0] value,
                               input logic [bda_pkg::FIELD_W-1:0] radix);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      gap        = $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_value <= value;
    in_radix <= radix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic void pick_palindrome(output logic [bda_pkg::FIELD_W-1:0] value,
                                          output logic [bda_pkg::FIELD_W-1:0] radix);
    longint unsigned acc;
    int unsigned     digs[12];
    int              n;
    int              i;
    bit              fits;
    radix = $urandom_range(2, 40);
    n     = $urandom_range(1, 12);
    fits  = 1'b0;
    acc   = 0;
    while (!fits) begin
      for (i = 0; i < (n + 1) / 2; i++) begin
        digs[i] = (i == 0) ? $urandom_range(1, radix - 1) : $urandom_range(0, radix - 1);
        digs[n - 1 - i] = digs[i];
      end
      acc  = 0;
      fits = 1'b1;
      for (i = 0; i < n; i++) begin
        acc = acc * radix + digs[i];
        if (acc > 64'hFFFF_FFFF) begin
          fits = 1'b0;
          break;
        end
      end
      if (!fits) n--;
    end
    value = acc[bda_pkg::FIELD_W-1:0];
  endfunction

  function automatic void pick_request(output logic [bda_pkg::FIELD_W-1:0] value,
                                       output logic [bda_pkg::FIELD_W-1:0] radix);
    int              pick;
    longint unsigned power;
    longint unsigned base;
    pick  = $urandom_range(0, 99);
    value = $urandom;
    if (pick < 6) begin
      radix = $urandom_range(0, 1);
    end else if (pick < 12) begin
      value = '0;
      radix = ($urandom_range(0, 1) == 0) ? $urandom_range(2, 40) : $urandom;
      if (radix < bda_pkg::MIN_RADIX) radix = bda_pkg::MIN_RADIX;
    end else if (pick < 30) begin
      pick_palindrome(value, radix);
    end else if (pick < 42) begin
      radix = $urandom_range(2, 3);
    end else if (pick < 62) begin
      value = value >> $urandom_range(0, 31);
      radix = $urandom_range(4, 36);
    end else if (pick < 74) begin
      // Values at and beside a power of the base move the digit count by one.
      base  = $urandom_range(2, 100);
      power = 1;
      repeat ($urandom_range(0, 32)) if (power * base <= 64'hFFFF_FFFF) power = power * base;
      power = power + $urandom_range(0, 2) - 1;
      value = power[bda_pkg::FIELD_W-1:0];
      radix = base[bda_pkg::FIELD_W-1:0];
    end else if (pick < 88) begin
      radix = $urandom_range(37, 65535);
    end else begin
      radix = $urandom;
      if ($urandom_range(0, 1) == 0) radix[bda_pkg::FIELD_W-1] = 1'b1;
      if (radix < bda_pkg::MIN_RADIX) radix = bda_pkg::MIN_RADIX;
    end
  endfunction

  initial begin : result_sink
    sink_mode_t mode;
    int         mode_left;
    int         phase;
    int         period;
    int         i;
    mode      = SINK_OPEN;
    mode_left = 0;
    phase     = 0;
    period    = 2;
    forever begin
      @(posedge clk);
      if (long_hold_wanted) begin
        long_hold_wanted = 1'b0;
        out_ready <= 1'b0;
        for (i = 0; i < LONG_HOLD; i++) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode      = sink_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 300);
        phase     = 0;
        period    = $urandom_range(2, 5);
      end
      mode_left--;
      case (mode)
        SINK_OPEN: begin
          out_ready <= 1'b1;
        end
        SINK_RANDOM: begin
          out_ready <= ($urandom_range(0, 99) < 60);
        end
        default: begin
          out_ready <= (phase == 0);
          phase = (phase + 1) % period;
        end
      endcase
    end
  end

  initial begin : stimulus
    logic [bda_pkg::FIELD_W-1:0] value;
    logic [bda_pkg::FIELD_W-1:0] radix;
    int                          n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Bases below two, zero values, single digits, long base-two values and wrapping reversals.
    offer_request(32'h0000_0000, 32'h0000_0000);
    offer_request(32'h0000_3039, 32'h0000_0000);
    offer_request(32'hFFFF_FFFF, 32'h0000_0001);
    offer_request(32'h0000_0000, 32'h0000_0001);
    offer_request(32'h0000_0000, 32'h0000_0002);
    offer_request(32'h0000_0000, 32'hFFFF_FFFF);
    offer_request(32'h0000_0001, 32'h0000_0002);
    offer_request(32'hFFFF_FFFF, 32'h0000_0002);
    offer_request(32'h8000_0001, 32'h0000_0002);
    offer_request(32'h7FFF_FFFF, 32'h0000_0002);
    offer_request(32'hAAAA_AAAA, 32'h0000_0002);
    offer_request(32'd121, 32'd10);
    offer_request(32'd1234567890, 32'd10);
    offer_request(32'hFFFF_FFFF, 32'd10);
    offer_request(32'hFFFF_FFFE, 32'd3);
    offer_request(32'd7, 32'd10);
    offer_request(32'd1000000000, 32'd10);
    offer_request(32'h1234_5678, 32'd16);
    offer_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    offer_request(32'hFFFF_FFFF, 32'h8000_0000);
    offer_request(32'h5555_AAAA, 32'h0001_0000);
    offer_request(32'd1296, 32'd36);

    // Keep offering requests while the result side holds off, so the block backs up.
    long_hold_wanted = 1'b1;
    burst_left       = 40;
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      pick_request(value, radix);
      offer_request(value, radix);
    end
    in_valid <= 1'b0;

    // The checker counts the last request at the edge it was taken, so wait for the next edge first.
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0)
      $display("base_digit_analyzer: match");
    else
      $display("base_digit_analyzer: mismatch");
    $finish;
  end

  initial begin : watchdog
    #80_000_000;
    $display("base_digit_analyzer: mismatch");
    $finish;
  end

endmodule

### base_digit_analyzer.f
src/bda_pkg.sv
src/bda_digit_unit.sv
src/base_digit_analyzer.sv
tb/base_digit_analyzer_checker.sv
tb/base_digit_analyzer_tb.sv
